// ----- src/c20pd_pkg.sv -----
// Shared types, constants and the quarter-round function for the pad derivation block.
package c20pd_pkg;

  localparam int MaxCount = 64;
  localparam int CntW = 7;
  localparam int RoundCount = 20;
  localparam logic [24:0] FullMod = 25'd16777216;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegMod = 3'd4;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_ROUND, ST_ADD, ST_MLOAD, ST_MSTEP, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic       init;
    logic       round;
    logic       diag;
    logic       add;
    logic       mload;
    logic       mstep;
    logic       emit;
    logic       last;
    logic [2:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic qr_t quarter(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] d);
    qr_t q;
    q.a = a + b;   q.d = rotl(d ^ q.a, 16);
    q.c = c + q.d; q.b = rotl(b ^ q.c, 12);
    q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 8);
    q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 7);
    quarter = q;
  endfunction

endpackage

// ----- src/chacha20_modular_pad_derivation.sv -----
// Top level of the ChaCha20 pad derivation block with modular reduction.
//   channel | direction | payload
//   s_*     | in        | tdata: group, index, start_block, count
//   m_*     | out       | tdata: value; tlast: last
//   cfg_*   | in        | key_part_0..3, modulus
// A block is made by the load, 20 rounds at one round per cycle, and the feed-forward add.
// Each value then passes through the one-bit-per-cycle remainder unit and is emitted.
// A new request waits until every item of the current one has been emitted; a zero-count
// request is accepted in idle and starts no block.
// A full output register holds the sequencer in its emit step until taken.
// Reset clears the keys to zero and the modulus to 2^24.
module chacha20_modular_pad_derivation import c20pd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // group[15:0], index[39:16], start_block[63:40], count[70:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // value[23:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cmd_t cmd;
  logic out_free;

  c20pd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_count (s_tdata[70:64]),
    .req_ready (s_tready),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  c20pd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_ctr   ({s_tdata[15:0], s_tdata[39:16], s_tdata[63:40]}),
    .cmd       (cmd),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ----- src/c20pd_ctrl.sv -----
// Sequencer for request intake, block rounds, bit-serial reduction and item output.
module c20pd_ctrl import c20pd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [CntW-1:0] req_count,
  output logic            req_ready,
  input  logic            out_free,
  output cmd_t            cmd
);

  state_t state, state_next;
  logic [CntW-1:0] n, k;
  logic [4:0] rnd;
  logic [5:0] bitcnt;
  logic [CntW-1:0] cnt_sat;
  logic is_last;

  assign cnt_sat = (req_count > CntW'(MaxCount)) ? CntW'(MaxCount) : req_count;
  assign is_last = (k == n - CntW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid && cnt_sat != '0) state_next = ST_INIT;
      ST_INIT:  state_next = ST_ROUND;
      ST_ROUND: if (rnd == 5'(RoundCount - 1)) state_next = ST_ADD;
      ST_ADD:   state_next = ST_MLOAD;
      ST_MLOAD: state_next = ST_MSTEP;
      ST_MSTEP: if (bitcnt == 6'd63) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (is_last) state_next = ST_IDLE;
          else if (k[2:0] == 3'd7) state_next = ST_INIT;
          else state_next = ST_MLOAD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    cmd = '0;
    cmd.start = (state == ST_IDLE) && req_valid;
    cmd.init = (state == ST_INIT);
    cmd.round = (state == ST_ROUND);
    cmd.diag = rnd[0];
    cmd.add = (state == ST_ADD);
    cmd.mload = (state == ST_MLOAD);
    cmd.mstep = (state == ST_MSTEP);
    cmd.emit = (state == ST_EMIT) && out_free;
    cmd.last = is_last;
    cmd.slot = k[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n <= '0;
      k <= '0;
      rnd <= '0;
      bitcnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        n <= cnt_sat;
        k <= '0;
      end
      if (state == ST_INIT) rnd <= '0;
      else if (state == ST_ROUND) rnd <= rnd + 5'd1;
      if (state == ST_MLOAD) bitcnt <= '0;
      else if (state == ST_MSTEP) bitcnt <= bitcnt + 6'd1;
      if (cmd.emit) k <= k + CntW'(1);
    end
  end

endmodule

// ----- src/c20pd_dp.sv -----
// Datapath: key and modulus registers, block counter, round state, reduction and output register.
module c20pd_dp import c20pd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] req_ctr,
  input  cmd_t        cmd,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_value,
  output logic        out_last
);

  logic [63:0] key0, key1, key2, key3;
  logic [24:0] modulus;
  logic [63:0] ctr;
  logic [31:0] w [16];
  logic [31:0] w_next [16];
  logic [31:0] init [16];
  logic [63:0] vsh;
  logic [23:0] r;
  logic [24:0] meff, r2;
  qr_t q0, q1, q2, q3;

  assign meff = (modulus == '0 || modulus > FullMod) ? FullMod : modulus;
  assign r2 = {r, vsh[63]};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
    init[4] = key0[31:0]; init[5] = key0[63:32];
    init[6] = key1[31:0]; init[7] = key1[63:32];
    init[8] = key2[31:0]; init[9] = key2[63:32];
    init[10] = key3[31:0]; init[11] = key3[63:32];
    init[12] = ctr[31:0]; init[13] = ctr[63:32];
    init[14] = '0; init[15] = '0;
  end

  always_comb begin
    w_next = w;
    if (!cmd.diag) begin
      q0 = quarter(w[0], w[4], w[8], w[12]);
      q1 = quarter(w[1], w[5], w[9], w[13]);
      q2 = quarter(w[2], w[6], w[10], w[14]);
      q3 = quarter(w[3], w[7], w[11], w[15]);
      w_next[0] = q0.a; w_next[4] = q0.b; w_next[8] = q0.c; w_next[12] = q0.d;
      w_next[1] = q1.a; w_next[5] = q1.b; w_next[9] = q1.c; w_next[13] = q1.d;
      w_next[2] = q2.a; w_next[6] = q2.b; w_next[10] = q2.c; w_next[14] = q2.d;
      w_next[3] = q3.a; w_next[7] = q3.b; w_next[11] = q3.c; w_next[15] = q3.d;
    end else begin
      q0 = quarter(w[0], w[5], w[10], w[15]);
      q1 = quarter(w[1], w[6], w[11], w[12]);
      q2 = quarter(w[2], w[7], w[8], w[13]);
      q3 = quarter(w[3], w[4], w[9], w[14]);
      w_next[0] = q0.a; w_next[5] = q0.b; w_next[10] = q0.c; w_next[15] = q0.d;
      w_next[1] = q1.a; w_next[6] = q1.b; w_next[11] = q1.c; w_next[12] = q1.d;
      w_next[2] = q2.a; w_next[7] = q2.b; w_next[8] = q2.c; w_next[13] = q2.d;
      w_next[3] = q3.a; w_next[4] = q3.b; w_next[9] = q3.c; w_next[14] = q3.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0; key1 <= '0; key2 <= '0; key3 <= '0;
      modulus <= FullMod;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKey0: key0 <= cfg_data;
        RegKey1: key1 <= cfg_data;
        RegKey2: key2 <= cfg_data;
        RegKey3: key3 <= cfg_data;
        RegMod:  modulus <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) ctr <= req_ctr;
    else if (cmd.add) ctr <= ctr + 64'd1;
    if (cmd.init) w <= init;
    else if (cmd.round) w <= w_next;
    else if (cmd.add) begin
      for (int i = 0; i < 16; i++) w[i] <= w[i] + init[i];
    end
    if (cmd.mload) begin
      vsh <= {w[{cmd.slot, 1'b1}], w[{cmd.slot, 1'b0}]};
      r <= '0;
    end else if (cmd.mstep) begin
      vsh <= {vsh[62:0], 1'b0};
      r <= (r2 >= meff) ? 24'(r2 - meff) : r2[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value <= r;
      out_last <= cmd.last;
    end
  end

endmodule

// ----- dv/tb_chacha20_modular_pad_derivation.sv -----
// Self-checking testbench for the ChaCha20 pad derivation block: streams random requests and checks every value.
module tb_chacha20_modular_pad_derivation;
  import c20pd_pkg::*;

  typedef struct packed {
    logic [23:0] value;
    logic        last;
  } pad_t;

  class pad_scoreboard;
    logic [63:0] key[4];
    logic [24:0] modulus;
    pad_t        pending[$];
    int          errors;

    function new();
      foreach (key[i]) key[i] = '0;
      modulus = FullMod;
      errors = 0;
    endfunction

    function automatic logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void qround(ref logic [31:0] w[16], input int a, int b, int c, int d);
      w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
    endfunction

    function automatic void keystream(logic [63:0] ctr, ref logic [31:0] ks[16]);
      logic [31:0] init[16];
      logic [31:0] w[16];
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i] = key[i][31:0];
        init[5 + 2 * i] = key[i][63:32];
      end
      init[12] = ctr[31:0];
      init[13] = ctr[63:32];
      init[14] = '0;
      init[15] = '0;
      w = init;
      for (int r = 0; r < 10; r++) begin
        qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
        qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
        qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
        qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] = w[i] + init[i];
    endfunction

    function void note_request(logic [71:0] d);
      logic [63:0] ctr;
      logic [63:0] m;
      logic [63:0] v;
      logic [31:0] ks[16];
      int          n;
      pad_t        p;
      n = d[70:64];
      if (n > MaxCount) n = MaxCount;
      m = modulus;
      if (m == 0 || m > FullMod) m = FullMod;
      ctr = {d[15:0], d[39:16], d[63:40]};
      for (int k = 0; k < n; k++) begin
        if ((k & 7) == 0) begin
          keystream(ctr, ks);
          ctr++;
        end
        v = {ks[2 * (k & 7) + 1], ks[2 * (k & 7)]};
        v = v % m;
        p.value = v[23:0];
        p.last = (k == n - 1);
        pending.push_back(p);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_value(logic [23:0] value, logic last);
      pad_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected value %h last %b", value, last));
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) report($sformatf("value %h, want %h", value, e.value));
      if (last !== e.last) report($sformatf("last %b, want %b", last, e.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // group, index, start_block, count
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // value
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  pad_scoreboard sb;
  bit          calm;
  longint      cycles = 0;

  chacha20_modular_pad_derivation u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd5000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_value(m_tdata, m_tlast);
  end

  // stall the receiver in random bursts until calm is set
  initial begin
    int n;
    m_tready = 0;
    @(negedge rst);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        m_tready <= 1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 16);
        m_tready <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == RegMod) sb.modulus = data[24:0];
    else sb.key[idx] = data;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send(logic [15:0] g, logic [23:0] ix, logic [23:0] st, logic [6:0] c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, c, st, ix, g};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request({1'b0, c, st, ix, g});
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [6:0] rnd_count();
    case ($urandom_range(0, 9))
      0: return 7'($urandom_range(65, 127));
      1: return 7'd0;
      2, 3: return 7'($urandom_range(9, 64));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    logic [24:0] mods[6];
    sb = new();
    calm = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = RegKey0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset keys and modulus, extremes of the fields
    send(16'h0000, 24'h000000, 24'h000000, 7'd8);
    send(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd9);
    send(16'h1234, 24'h00ABCD, 24'hFFFFFF, 7'd16);
    send(16'h0001, 24'h000001, 24'h000001, 7'd0);
    send(16'h8000, 24'h800000, 24'h7FFFFF, 7'd127);
    send(16'h00FF, 24'h123456, 24'h000010, 7'd1);
    drain();
    write_reg(RegKey0, 64'hFFFFFFFF_FFFFFFFF);
    write_reg(RegKey1, 64'h0123456789ABCDEF);
    write_reg(RegKey2, 64'hFEDCBA9876543210);
    write_reg(RegKey3, 64'hFFFFFFFF_FFFFFFFF);
    write_reg(RegMod, 64'd2);
    send(16'h5555, 24'hAAAAAA, 24'h555555, 7'd64);
    send(16'hAAAA, 24'h555555, 24'hAAAAAA, 7'd65);
    drain();
    write_reg(RegMod, 64'd1);
    send(16'h0F0F, 24'h0F0F0F, 24'hF0F0F0, 7'd5);
    drain();
    write_reg(RegMod, 64'd0);
    send(16'h3C3C, 24'hC3C3C3, 24'h3C3C3C, 7'd3);
    drain();
    write_reg(RegMod, 64'h1FFFFFF);
    send(16'hC3C3, 24'h3C3C3C, 24'hC3C3C3, 7'd10);
    drain();

    mods[0] = 25'd16777216; mods[1] = 25'd2; mods[2] = 25'd16777215;
    mods[3] = 25'd1000003;  mods[4] = 25'd0; mods[5] = 25'd16777217;
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(3'(r), rnd64());
      write_reg(RegMod, ph < 3 ? 64'(mods[ph]) :
                ($urandom_range(0, 1) ? 64'(mods[ph]) : 64'($urandom_range(2, 16777216))));
      if (ph == 5) calm = 1;
      for (int i = 0; i < 16; i++)
        send(16'($urandom), 24'($urandom),
             $urandom_range(0, 5) == 0 ? 24'hFFFFFF - 24'($urandom_range(0, 2)) : 24'($urandom),
             rnd_count());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/c20pd_pkg.sv
src/c20pd_ctrl.sv
src/c20pd_dp.sv
src/chacha20_modular_pad_derivation.sv
dv/tb_chacha20_modular_pad_derivation.sv
